/* hw/rtl/gbpg_pkg.sv */
`timescale 1ns / 1ps
package gbpg_pkg;
    localparam int MAX_BARS_DEF  = 16;
    localparam int MAX_STEPS_DEF = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VERTICAL    = 3'd5;

    // Dividend and divisor widths of the shared divider.
    localparam int NUM_W = 32;
    localparam int DEN_W = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAIN0,
        ST_MAIN1,
        ST_SUB,
        ST_COL,
        ST_WAIT,
        ST_EMIT,
        ST_DONE
    } gbpg_state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } gbpg_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
    } gbpg_div_rsp_t;
endpackage

/* hw/rtl/gbpg_divider.sv */
`timescale 1ns / 1ps
module gbpg_divider (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gbpg_pkg::gbpg_div_req_t req,
    output gbpg_pkg::gbpg_div_rsp_t rsp
);
    import gbpg_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
        if (req.start) begin
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
endmodule

/* hw/rtl/gbpg_sequencer.sv */
`timescale 1ns / 1ps
module gbpg_sequencer #(
    parameter int MAX_BARS  = gbpg_pkg::MAX_BARS_DEF,
    parameter int MAX_STEPS = gbpg_pkg::MAX_STEPS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [13:0]             origin_x,
    input  logic [13:0]             origin_y,
    input  logic [13:0]             area_width,
    input  logic [13:0]             area_height,
    input  logic [4:0]              bar_count,
    input  logic                    vertical_bars,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [71:0]             in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [95:0]             out_data,
    output gbpg_pkg::gbpg_div_req_t div_req,
    input  gbpg_pkg::gbpg_div_rsp_t div_rsp
);
    import gbpg_pkg::*;

    gbpg_state_t state_reg, state_next;

    logic [4:0]  bar_index_reg, bar_index_next;
    logic [13:0] main_off_reg, main_off_next;
    logic [6:0]  steps_reg, steps_next;
    logic [6:0]  k_reg, k_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [4:0]  bidx_reg, bidx_next;
    logic [7:0]  sc_reg [4];
    logic [7:0]  ec_reg [4];
    logic [7:0]  col_reg [4];
    logic [7:0]  col_next [4];
    logic [1:0]  ch_reg, ch_next;
    logic [1:0]  phase_reg, phase_next;
    logic [13:0] edge_a_reg, edge_a_next;
    logic [13:0] main_len_reg, main_len_next;
    logic [13:0] sub_pos_reg, sub_pos_next;
    logic [13:0] sub_len_reg, sub_len_next;
    logic [95:0] out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic [4:0]  count_eff;
    logic [6:0]  steps_in;
    logic [13:0] main_size, sub_size;
    logic [6:0]  dsteps;
    logic [15:0] rnum;
    logic [14:0] x_w, y_w;
    logic [13:0] w_w, h_w;
    logic        lbar;

    assign count_eff = (int'(bar_count) > MAX_BARS) ? 5'(MAX_BARS) : bar_count;
    assign steps_in  = (in_data[6:0] > 7'(MAX_STEPS)) ? 7'(MAX_STEPS) : in_data[6:0];
    assign main_size = vertical_bars ? area_width : area_height;
    assign sub_size  = vertical_bars ? area_height : area_width;
    assign dsteps    = steps_reg - 7'd1;
    assign rnum      = 16'(sc_reg[ch_reg]) * 16'(dsteps - k_reg)
                     + 16'(ec_reg[ch_reg]) * 16'(k_reg);
    assign lbar      = (bidx_reg == count_eff - 5'd1);

    always_comb begin
        if (vertical_bars) begin
            x_w = 15'(origin_x) + 15'(main_off_reg);
            y_w = 15'(origin_y) + 15'(sub_pos_reg);
            w_w = main_len_reg;
            h_w = sub_len_reg;
        end else begin
            x_w = 15'(origin_x) + 15'(sub_pos_reg);
            y_w = 15'(origin_y) + 15'(main_off_reg);
            w_w = sub_len_reg;
            h_w = main_len_reg;
        end
    end

    always_comb begin
        state_next     = state_reg;
        bar_index_next = bar_index_reg;
        main_off_next  = main_off_reg;
        steps_next     = steps_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        bidx_next      = bidx_reg;
        ch_next        = ch_reg;
        phase_next     = phase_reg;
        edge_a_next    = edge_a_reg;
        main_len_next  = main_len_reg;
        sub_pos_next   = sub_pos_reg;
        sub_len_next   = sub_len_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        for (int i = 0; i < 4; i++) col_next[i] = col_reg[i];
        div_req        = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready) out_valid_next = 1'b0;

        unique case (state_reg) inside
            ST_IDLE: begin
                // With no bars configured a transfer is taken and dropped.
                in_ready = 1'b1;
                if (in_valid && bar_count != 5'd0) begin
                    steps_next = steps_in;
                    cnt_next   = count_eff;
                    k_next     = '0;
                    if (bar_index_reg >= count_eff) begin
                        bidx_next     = '0;
                        main_off_next = '0;
                    end else begin
                        bidx_next = bar_index_reg;
                    end
                    if (steps_in == 7'd0) begin
                        state_next = ST_DONE;
                    end else begin
                        phase_next = 2'd0;
                        state_next = ST_MAIN0;
                    end
                end
            end
            // Main-axis edges: round(size*i/n) = (2*size*i + n) / (2n).
            ST_MAIN0, ST_MAIN1: begin
                if (!div_rsp.busy && !div_rsp.done && phase_reg == 2'd0) begin
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'({main_size, 1'b0})
                                  * NUM_W'((state_reg == ST_MAIN0) ? bidx_reg
                                                                   : bidx_reg + 5'd1)
                                  + NUM_W'(cnt_reg);
                    div_req.den   = DEN_W'({cnt_reg, 1'b0});
                    phase_next    = 2'd1;
                end else if (div_rsp.done) begin
                    phase_next = 2'd0;
                    if (state_reg == ST_MAIN0) begin
                        edge_a_next = div_rsp.quot[13:0];
                        state_next  = ST_MAIN1;
                    end else begin
                        main_len_next = div_rsp.quot[13:0] - edge_a_reg;
                        sub_pos_next  = '0;
                        state_next    = ST_SUB;
                    end
                end
            end
            // Upper sub-axis edge of step k; the lower one is the previous upper edge.
            ST_SUB: begin
                if (!div_rsp.busy && !div_rsp.done && phase_reg == 2'd0) begin
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'({sub_size, 1'b0}) * NUM_W'(k_reg + 7'd1)
                                  + NUM_W'(steps_reg);
                    div_req.den   = DEN_W'({steps_reg, 1'b0});
                    phase_next    = 2'd1;
                end else if (div_rsp.done) begin
                    phase_next   = 2'd0;
                    sub_len_next = div_rsp.quot[13:0] - sub_pos_reg;
                    ch_next      = 2'd0;
                    state_next   = ST_COL;
                end
            end
            ST_COL: begin
                if (steps_reg == 7'd1) begin
                    for (int i = 0; i < 4; i++) col_next[i] = sc_reg[i];
                    state_next = ST_WAIT;
                end else if (!div_rsp.busy && !div_rsp.done && phase_reg == 2'd0) begin
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'({rnum, 1'b0}) + NUM_W'(dsteps);
                    div_req.den   = DEN_W'({dsteps, 1'b0});
                    phase_next    = 2'd1;
                end else if (div_rsp.done) begin
                    phase_next       = 2'd0;
                    col_next[ch_reg] = div_rsp.quot[7:0];
                    ch_next          = ch_reg + 2'd1;
                    if (ch_reg == 2'd3) state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!out_valid_reg || out_ready) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                out_valid_next = 1'b1;
                out_next = {4'd0, lbar, (k_reg == dsteps), col_reg[3], col_reg[2],
                            col_reg[1], col_reg[0], h_w, w_w, y_w, x_w};
                sub_pos_next = sub_pos_reg + sub_len_reg;
                if (k_reg == dsteps) begin
                    main_off_next = main_off_reg + main_len_reg;
                    state_next    = ST_DONE;
                end else begin
                    k_next     = k_reg + 7'd1;
                    state_next = ST_SUB;
                end
            end
            ST_DONE: begin
                if (bidx_reg + 5'd1 >= cnt_reg) begin
                    bar_index_next = '0;
                    main_off_next  = '0;
                end else begin
                    bar_index_next = bidx_reg + 5'd1;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bar_index_reg <= '0;
            main_off_reg  <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            bar_index_reg <= bar_index_next;
            main_off_reg  <= main_off_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
        steps_reg    <= steps_next;
        k_reg        <= k_next;
        cnt_reg      <= cnt_next;
        bidx_reg     <= bidx_next;
        ch_reg       <= ch_next;
        edge_a_reg   <= edge_a_next;
        main_len_reg <= main_len_next;
        sub_pos_reg  <= sub_pos_next;
        sub_len_reg  <= sub_len_next;
        out_reg      <= out_next;
        for (int i = 0; i < 4; i++) col_reg[i] <= col_next[i];
        if (state_reg == ST_IDLE && in_valid && in_ready) begin
            for (int i = 0; i < 4; i++) begin
                sc_reg[i] <= in_data[7 + 8*i +: 8];
                ec_reg[i] <= in_data[39 + 8*i +: 8];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

/* hw/rtl/gradient_bar_pattern_generator_unit.sv */
`timescale 1ns / 1ps
// Each bar uses the shared divider: a bar of n >= 2 steps takes 2 + 5*n
// divider passes; a one-step bar takes no colour passes and a zero-step bar none.
// Throughput: one bar item at a time; all divisions share the one divider.
// Reset: aresetn synchronous, active low; the configuration registers return
// to their defaults, the bar index and main offset clear to zero.
module gradient_bar_pattern_generator_unit #(
    parameter int MAX_BARS  = gbpg_pkg::MAX_BARS_DEF,
    parameter int MAX_STEPS = gbpg_pkg::MAX_STEPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [gbpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbpg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // bar_steps[6:0], start r,g,b,a, end r,g,b,a (8 bits each), zero pad
    input  logic [71:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // rect_x[14:0], rect_y[29:15], rect_width[43:30], rect_height[57:44],
    // fill r,g,b,a [89:58], zero pad
    output logic [95:0]                     m_tdata,
    output logic                            m_tlast,
    // last_bar
    output logic                            m_tuser
);
    import gbpg_pkg::*;

    logic [13:0] origin_x_reg, origin_y_reg, area_w_reg, area_h_reg;
    logic [4:0]  bar_count_reg;
    logic        vertical_reg;
    logic [95:0] seq_data;
    gbpg_div_req_t div_req;
    gbpg_div_rsp_t div_rsp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            area_w_reg    <= 14'd1920;
            area_h_reg    <= 14'd1080;
            bar_count_reg <= 5'd4;
            vertical_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORIGIN_X:    origin_x_reg  <= cfg_data[13:0];
                REG_ORIGIN_Y:    origin_y_reg  <= cfg_data[13:0];
                REG_AREA_WIDTH:  area_w_reg    <= cfg_data[13:0];
                REG_AREA_HEIGHT: area_h_reg    <= cfg_data[13:0];
                REG_BAR_COUNT:   bar_count_reg <= cfg_data[4:0];
                REG_VERTICAL:    vertical_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    gbpg_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp)
    );

    gbpg_sequencer #(.MAX_BARS(MAX_BARS), .MAX_STEPS(MAX_STEPS)) u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .origin_x(origin_x_reg), .origin_y(origin_y_reg),
        .area_width(area_w_reg), .area_height(area_h_reg),
        .bar_count(bar_count_reg), .vertical_bars(vertical_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(seq_data),
        .div_req(div_req), .div_rsp(div_rsp)
    );

    assign m_tdata = {6'd0, seq_data[89:0]};
    assign m_tlast = seq_data[90];
    assign m_tuser = seq_data[91];
endmodule

/* hw/rtl/gbpg_checker.sv */
`timescale 1ns / 1ps
module gbpg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tlast
);
    // A result waiting to be taken holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Handshake outputs are always driven to known levels out of reset.
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_tready, m_tvalid}))
        else $error("handshake output unknown");

    // Padding bits stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[95:90] == 6'd0)
        else $error("padding bits set");

    // An accepted last step is not followed by another accepted last step in the next cycle.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !(m_tvalid && m_tready && m_tlast))
        else $error("two last steps in a row");
endmodule

bind gradient_bar_pattern_generator_unit gbpg_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

/* dv/gradient_bar_pattern_generator_unit_test.sv */
`timescale 1ns / 1ps
module gradient_bar_pattern_generator_unit_test;
    import gbpg_pkg::*;

    typedef struct packed {
        logic [6:0] steps;
        logic [7:0] sr, sg, sb, sa, er, eg, eb, ea;
    } bar_item_t;

    typedef struct packed {
        logic [14:0] x;
        logic [14:0] y;
        logic [13:0] w;
        logic [13:0] h;
        logic [7:0]  r, g, b, a;
        logic        last_step;
        logic        last_bar;
    } rect_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [71:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic m_tlast;
    logic m_tuser;

    gradient_bar_pattern_generator_unit DUT (.*);

    always #10 aclk = ~aclk;

    // Predictor copy of the registers and the frame position.
    int unsigned org_x, org_y, width_px, height_px, n_bars, vert;
    int unsigned cur_bar, cur_offset;

    bar_item_t pending_bars[$];
    rect_t     expected_rects[$];
    int        errors = 0;
    int        rects_seen = 0;
    int        bars_sent = 0;
    int        send_idle = 0;
    int        recv_stall = 0;
    bit        feed_hold = 1'b0;

    function automatic int unsigned edge_pos(int unsigned size, int unsigned i,
                                             int unsigned n);
        return (2 * size * i + n) / (2 * n);
    endfunction

    function automatic int unsigned mix(int unsigned s, int unsigned e,
                                        int unsigned k, int unsigned n);
        int unsigned d;
        if (n <= 1) return s;
        d = n - 1;
        return (2 * (s * (d - k) + e * k) + d) / (2 * d);
    endfunction

    task automatic predict_bar(bar_item_t it);
        int unsigned cnt, steps, msz, ssz, mlen, spos, slen, lb;
        int unsigned sc[4], ec[4];
        rect_t r;
        cnt = n_bars;
        if (cnt == 0) return;
        if (cnt > 16) cnt = 16;
        if (cur_bar >= cnt) begin
            cur_bar = 0;
            cur_offset = 0;
        end
        steps = it.steps > 64 ? 64 : it.steps;
        sc = '{it.sr, it.sg, it.sb, it.sa};
        ec = '{it.er, it.eg, it.eb, it.ea};
        msz = vert ? width_px : height_px;
        ssz = vert ? height_px : width_px;
        mlen = edge_pos(msz, cur_bar + 1, cnt) - edge_pos(msz, cur_bar, cnt);
        lb = (cur_bar == cnt - 1);
        for (int unsigned k = 0; k < steps; k++) begin
            spos = edge_pos(ssz, k, steps);
            slen = edge_pos(ssz, k + 1, steps) - spos;
            if (vert) begin
                r.x = 15'(org_x + cur_offset); r.y = 15'(org_y + spos);
                r.w = 14'(mlen); r.h = 14'(slen);
            end else begin
                r.x = 15'(org_x + spos); r.y = 15'(org_y + cur_offset);
                r.w = 14'(slen); r.h = 14'(mlen);
            end
            r.r = 8'(mix(sc[0], ec[0], k, steps));
            r.g = 8'(mix(sc[1], ec[1], k, steps));
            r.b = 8'(mix(sc[2], ec[2], k, steps));
            r.a = 8'(mix(sc[3], ec[3], k, steps));
            r.last_step = (k == steps - 1);
            r.last_bar = 1'(lb);
            expected_rects.push_back(r);
        end
        if (steps > 0) cur_offset = (cur_offset + mlen) & 14'h3fff;
        cur_bar++;
        if (cur_bar >= cnt) begin
            cur_bar = 0;
            cur_offset = 0;
        end
    endtask

    // Driver: a transfer leaves the queue when accepted; the item is predicted then.
    always @(posedge aclk) begin
        bar_item_t it;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_bar(pending_bars.pop_front());
                bars_sent++;
            end
            if (pending_bars.size() > 0 && !feed_hold &&
                    !(send_idle > 0 && $urandom_range(99) < send_idle)) begin
                it = pending_bars[0];
                s_tdata <= {1'b0, it.ea, it.eb, it.eg, it.er, it.sa, it.sb, it.sg,
                            it.sr, it.steps};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
            m_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        rect_t e;
        if (aresetn && m_tvalid && m_tready) begin
            rects_seen++;
            if (expected_rects.size() == 0) begin
                $error("unexpected rectangle %h", m_tdata);
                errors++;
            end else begin
                e = expected_rects.pop_front();
                if (m_tdata[14:0] !== e.x) begin
                    $error("rect_x exp %0d got %0d", e.x, m_tdata[14:0]); errors++;
                end
                if (m_tdata[29:15] !== e.y) begin
                    $error("rect_y exp %0d got %0d", e.y, m_tdata[29:15]); errors++;
                end
                if (m_tdata[43:30] !== e.w) begin
                    $error("rect_width exp %0d got %0d", e.w, m_tdata[43:30]); errors++;
                end
                if (m_tdata[57:44] !== e.h) begin
                    $error("rect_height exp %0d got %0d", e.h, m_tdata[57:44]);
                    errors++;
                end
                if (m_tdata[65:58] !== e.r) begin
                    $error("fill_red exp %0d got %0d", e.r, m_tdata[65:58]); errors++;
                end
                if (m_tdata[73:66] !== e.g) begin
                    $error("fill_green exp %0d got %0d", e.g, m_tdata[73:66]); errors++;
                end
                if (m_tdata[81:74] !== e.b) begin
                    $error("fill_blue exp %0d got %0d", e.b, m_tdata[81:74]); errors++;
                end
                if (m_tdata[89:82] !== e.a) begin
                    $error("fill_alpha exp %0d got %0d", e.a, m_tdata[89:82]); errors++;
                end
                if (m_tlast !== e.last_step) begin
                    $error("last_step exp %0d got %0d", e.last_step, m_tlast); errors++;
                end
                if (m_tuser !== e.last_bar) begin
                    $error("last_bar exp %0d got %0d", e.last_bar, m_tuser); errors++;
                end
            end
        end
    end

    function automatic bar_item_t rand_bar(int unsigned max_steps);
        bar_item_t it;
        it = 71'({$urandom, $urandom, $urandom});
        it.steps = 7'($urandom_range(max_steps));
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_bars.size() > 0 || s_tvalid || expected_rects.size() > 0)
            @(posedge aclk);
        // A zero-step bar may still be in progress after the last rectangle.
        repeat (12000) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ORIGIN_X:    org_x = val & 14'h3fff;
            REG_ORIGIN_Y:    org_y = val & 14'h3fff;
            REG_AREA_WIDTH:  width_px = val & 14'h3fff;
            REG_AREA_HEIGHT: height_px = val & 14'h3fff;
            REG_BAR_COUNT:   n_bars = val & 5'h1f;
            REG_VERTICAL:    vert = val & 1;
            default: ;
        endcase
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle = idle;
        recv_stall = stall;
        for (int i = 0; i < n; i++)
            pending_bars.push_back(rand_bar($urandom_range(9) == 0 ? 127 :
                                   ($urandom_range(3) == 0 ? 64 : 12)));
        wait_drained();
    endtask

    initial begin
        bar_item_t it;
        org_x = 0; org_y = 0; width_px = 1920; height_px = 1080;
        n_bars = 4; vert = 0; cur_bar = 0; cur_offset = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes of steps and colours, one step, zero step, wrap.
        it = '{7'd1, 8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00, 8'hff, 8'h00};
        pending_bars.push_back(it);
        it = '{7'd64, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00};
        pending_bars.push_back(it);
        it = '{7'd0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc, 8'hde, 8'hf0};
        pending_bars.push_back(it);
        it = '{7'd2, 8'h00, 8'h01, 8'hfe, 8'hff, 8'h01, 8'h00, 8'hff, 8'hfe};
        pending_bars.push_back(it);
        it = '{7'd127, 8'h55, 8'haa, 8'h55, 8'haa, 8'haa, 8'h55, 8'haa, 8'h55};
        pending_bars.push_back(it);
        it = '{7'd3, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'h7f, 8'h80, 8'hfe, 8'h01};
        pending_bars.push_back(it);
        wait_drained();

        random_phase(60, 0, 0);

        write_reg(REG_VERTICAL, 1);
        write_reg(REG_BAR_COUNT, 16);
        write_reg(REG_ORIGIN_X, 16383);
        write_reg(REG_ORIGIN_Y, 16383);
        write_reg(REG_AREA_WIDTH, 16383);
        write_reg(REG_AREA_HEIGHT, 16383);
        random_phase(60, 47, 0);

        // Stale bar index after shrinking the count, then a zero count and an over-large count.
        write_reg(REG_BAR_COUNT, 1);
        write_reg(REG_VERTICAL, 0);
        write_reg(REG_AREA_WIDTH, 7);
        write_reg(REG_AREA_HEIGHT, 0);
        random_phase(40, 0, 47);

        write_reg(REG_BAR_COUNT, 0);
        random_phase(10, 0, 0);
        write_reg(REG_BAR_COUNT, 31);
        write_reg(REG_AREA_WIDTH, 640);
        write_reg(REG_AREA_HEIGHT, 13);
        write_reg(REG_ORIGIN_X, 5);
        write_reg(REG_ORIGIN_Y, 0);
        random_phase(60, 37, 37);

        // Hold the feed, send the queue, hold until all rectangles are back, resume.
        feed_hold = 1'b1;
        for (int i = 0; i < 5; i++) pending_bars.push_back(rand_bar(64));
        repeat (50) @(posedge aclk);
        feed_hold = 1'b0;
        while (pending_bars.size() > 0) @(posedge aclk);
        feed_hold = 1'b1;
        while (expected_rects.size() > 0) @(posedge aclk);
        feed_hold = 1'b0;

        write_reg(REG_BAR_COUNT, 3);
        write_reg(REG_VERTICAL, 1);
        write_reg(REG_AREA_WIDTH, 1000);
        write_reg(REG_AREA_HEIGHT, 333);
        random_phase(120, 37, 37);

        $display("Sent %0d bars and checked %0d rectangles over six register settings.",
                 bars_sent, rects_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #1000ms;
        $display("Mismatches found");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/gbpg_pkg.sv
hw/rtl/gbpg_divider.sv
hw/rtl/gbpg_sequencer.sv
hw/rtl/gradient_bar_pattern_generator_unit.sv
hw/rtl/gbpg_checker.sv
dv/gradient_bar_pattern_generator_unit_test.sv
